// File: rtl/lis_pkg.sv
package lis_pkg;

    // Item field widths
    localparam int VAL_W = 32;
    localparam int LEN_W = 11;

    // Tail table depth, one cell per entry
    localparam int MAX_LEN = 1024;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Append-flag reduction: groups of GRP_W cells, then one OR over the groups
    localparam int GRP_W  = 32;
    localparam int NGRP   = (MAX_LEN + GRP_W - 1) / GRP_W;
    localparam int PAD_W  = NGRP * GRP_W;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // compare against the key and update
        logic clr;      // drop all entries (end of sequence)
    } t_cell_ctrl;

endpackage

// File: rtl/lis_if.sv
// Input channel: one sequence element per item
interface lis_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [lis_pkg::VAL_W-1:0]  value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// Output channel: one result item per input item
interface lis_out_if;
    logic                       valid;
    logic                       ready;
    logic [lis_pkg::LEN_W-1:0]  length;
    logic                       overflow;
    logic                       done_res;

    modport source (output valid, output length, output overflow, output done_res,
                    input ready);
    modport sink   (input valid, input length, input overflow, input done_res,
                    output ready);
endinterface

// File: rtl/lis_cell.sv
// One entry of the sorted tail table.
// The cell's "not less" flag is monotone along the chain (free cells count as
// +infinity), so the first such cell is found by looking at the left neighbor.
module lis_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lis_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [lis_pkg::VAL_W-1:0]  i_key,
    input  logic                              i_geq_prev,
    output logic                              o_geq,
    output logic                              o_inuse,
    output logic                              o_app
);

    logic                              r_inuse;
    logic                              r_app;
    logic signed [lis_pkg::VAL_W-1:0]  r_tail;
    logic                              w_hit;

    // Free cell or tail >= key; this cell is the target if the left one is not
    assign o_geq   = !r_inuse || (r_tail >= i_key);
    assign w_hit   = o_geq && !i_geq_prev;
    assign o_inuse = r_inuse;
    assign o_app   = r_app;

    // Occupancy and append marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inuse <= 1'b0;
            r_app   <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_inuse <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_app <= w_hit && !r_inuse;
            if (w_hit) begin
                r_inuse <= 1'b1;
            end
        end
    end

    // Tail value, replaced or appended
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en && w_hit) begin
            r_tail <= i_key;
        end
    end

endmodule

// File: rtl/lis_length_patience.sv
// Longest strictly increasing subsequence length, patience-sorting form.
// i_in carries one signed 32-bit element per item plus a last flag. o_out
// returns one result item per element: the running LIS length (table size),
// a sticky overflow flag for appends dropped on a full table, and done_res
// echoing last. Both channels move an item when valid and ready are high.
// The tail table is a row of MAX_LEN cells; each compares the element with
// its own tail in the same cycle and the target cell is found from the left
// neighbor alone. The append flags are then OR-reduced in two registered
// stages and the length counter updated.
// Each element passes through accept, compare, two reduction stages and
// output load; the block holds one element at a time and accepts the next
// only once the previous result has been loaded into the output register.
// A waiting result sits in the output register; the next element is accepted
// meanwhile, but its result waits until the receiver takes the previous one.
// Reset (synchronous, active low) empties the table and clears the length and
// overflow state. After a last element's result is loaded, they clear again.
module lis_length_patience (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lis_in_if.sink     i_in,
    lis_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED1,
        S_RED2,
        S_OUT
    } t_state;

    t_state                                 r_state;
    logic signed [lis_pkg::VAL_W-1:0]       r_key;
    logic                                   r_last;
    logic                                   r_ovf_evt;
    logic [lis_pkg::NGRP-1:0]               r_grp;
    logic [lis_pkg::CNT_W-1:0]              r_count;
    logic                                   r_ovf;
    logic [lis_pkg::LEN_W-1:0]              r_res_len;
    logic                                   r_res_ovf;
    logic                                   r_res_last;
    logic                                   r_ov;
    logic [lis_pkg::LEN_W-1:0]              r_o_len;
    logic                                   r_o_ovf;
    logic                                   r_o_done;

    logic [lis_pkg::MAX_LEN-1:0]            w_geq;
    logic [lis_pkg::MAX_LEN-1:0]            w_inuse;
    logic [lis_pkg::MAX_LEN-1:0]            w_app;
    logic [lis_pkg::PAD_W-1:0]              w_app_pad;
    logic [lis_pkg::CNT_W-1:0]              n_count;
    logic                                   w_load;
    lis_pkg::t_cell_ctrl                    w_ctrl;

    // Handshake and cell commands
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_load      = (r_state == S_OUT) && (!r_ov || o_out.ready);
    assign w_ctrl.cmp_en = (r_state == S_CMP);
    assign w_ctrl.clr    = w_load && r_last;

    // Row of table cells
    for (genvar gi = 0; gi < lis_pkg::MAX_LEN; gi++) begin : g_cell
        logic w_prev;
        if (gi == 0) begin : g_first
            assign w_prev = 1'b0;
        end else begin : g_rest
            assign w_prev = w_geq[gi-1];
        end
        lis_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_key      (r_key),
            .i_geq_prev (w_prev),
            .o_geq      (w_geq[gi]),
            .o_inuse    (w_inuse[gi]),
            .o_app      (w_app[gi])
        );
    end

    // Append flags padded to whole groups
    assign w_app_pad = lis_pkg::PAD_W'(w_app);
    assign n_count   = r_count + lis_pkg::CNT_W'(|r_grp);

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key  <= i_in.value;
            r_last <= i_in.last;
        end
    end

    // First-stage group OR of append flags
    always_ff @(posedge i_clk) begin
        if (r_state == S_RED1) begin
            for (int g = 0; g < lis_pkg::NGRP; g++) begin
                r_grp[g] <= |w_app_pad[g*lis_pkg::GRP_W +: lis_pkg::GRP_W];
            end
        end
    end

    // Sequencer, length/overflow state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_ovf_evt <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            // output valid: set on load, cleared once taken
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // no cell qualifies only when every cell holds a smaller tail
                    r_ovf_evt <= !w_geq[lis_pkg::MAX_LEN-1];
                    r_state   <= S_RED1;
                end
                S_RED1: begin
                    r_state <= S_RED2;
                end
                S_RED2: begin
                    r_count    <= n_count;
                    r_ovf      <= r_ovf | r_ovf_evt;
                    r_res_len  <= lis_pkg::LEN_W'(n_count);
                    r_res_ovf  <= r_ovf | r_ovf_evt;
                    r_res_last <= r_last;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_o_len  <= r_res_len;
                        r_o_ovf  <= r_res_ovf;
                        r_o_done <= r_res_last;
                        if (r_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.length   = r_o_len;
    assign o_out.overflow = r_o_ovf;
    assign o_out.done_res = r_o_done;

    // Occupied cells always form a prefix of the row
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_inuse[lis_pkg::MAX_LEN-1:1] & ~w_inuse[lis_pkg::MAX_LEN-2:0]) == '0)
        else $error("occupied cells are not a prefix");

    // Length counter tracks the occupied cells between items
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_inuse) == int'(r_count)))
        else $error("length counter disagrees with cell occupancy");

    // At most one cell appends per element
    a_one_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_app))
        else $error("more than one cell appended");

    // A dropped append only happens on a full table
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED2 && r_ovf_evt) |-> (int'(r_count) == lis_pkg::MAX_LEN))
        else $error("overflow on a table that is not full");

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MIN_INT     = 32'sh8000_0000;
    localparam int MAX_INT     = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [lis_pkg::VAL_W-1:0] value;
        logic                             last;
    } t_element;

    typedef struct {
        logic [lis_pkg::LEN_W-1:0] length;
        logic                      overflow;
        logic                      done_res;
    } t_lis_result;

    // Tracks the tail table and queues the length each element should produce
    class lis_tracker;
        logic signed [lis_pkg::VAL_W-1:0] tails [lis_pkg::MAX_LEN];
        int                               used;
        bit                               ovf_seen;
        t_lis_result                      pending_q[$];
        int                               errors;

        function void note_element(logic signed [lis_pkg::VAL_W-1:0] v, logic l);
            t_lis_result r;
            int          pos;
            pos = used;
            for (int i = 0; i < used; i++) begin
                if (tails[i] >= v) begin
                    pos = i;
                    break;
                end
            end
            if (pos < used) begin
                tails[pos] = v;
            end else if (used < lis_pkg::MAX_LEN) begin
                tails[used] = v;
                used++;
            end else begin
                ovf_seen = 1'b1;
            end
            r.length   = lis_pkg::LEN_W'(used);
            r.overflow = ovf_seen;
            r.done_res = l;
            pending_q.insert(pending_q.size(), r);
            // end of sequence empties the table
            if (l) begin
                used     = 0;
                ovf_seen = 1'b0;
            end
        endfunction

        function void check_result(t_lis_result got);
            t_lis_result exp_r;
            if (pending_q.size() == 0) begin
                $error("unexpected result item: length=%0d overflow=%0b done_res=%0b",
                       got.length, got.overflow, got.done_res);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.length !== exp_r.length) begin
                $error("length: expected %0d, got %0d", exp_r.length, got.length);
                errors++;
            end
            if (got.overflow !== exp_r.overflow) begin
                $error("overflow: expected %0b, got %0b", exp_r.overflow, got.overflow);
                errors++;
            end
            if (got.done_res !== exp_r.done_res) begin
                $error("done_res: expected %0b, got %0b", exp_r.done_res, got.done_res);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    int         cycle_count = 0;
    lis_tracker tracker;
    t_element   elements_q[$];

    lis_in_if  in_ch();
    lis_out_if out_ch();

    lis_length_patience uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Run-length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic add_element(int v, bit l);
        t_element e;
        e.value = v;
        e.last  = l;
        elements_q.insert(elements_q.size(), e);
    endtask

    // Directed: single element, extremes, equal values, decreasing runs
    task automatic add_directed();
        add_element(0, 1);
        add_element(MIN_INT, 0);
        add_element(-1, 0);
        add_element(0, 0);
        add_element(1, 0);
        add_element(MAX_INT, 0);
        add_element(MAX_INT, 0);
        add_element(MIN_INT, 0);
        add_element(5, 1);
        add_element(10, 0);
        add_element(9, 0);
        add_element(8, 0);
        add_element(8, 0);
        add_element(7, 1);
        add_element(3, 0);
        add_element(3, 0);
        add_element(3, 1);
        add_element(MAX_INT, 0);
        add_element(MIN_INT, 0);
        add_element(32'sh5555_5555, 0);
        add_element(32'shAAAA_AAAA, 0);
        add_element(100, 0);
        add_element(101, 1);
    endtask

    // Short sequence with one of several value profiles
    task automatic add_short_seq();
        int n;
        int mode;
        int v;
        int base;
        n    = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        base = $urandom;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: v = $urandom;
                1: v = int'($urandom_range(0, 15)) - 8;
                2: begin
                    base = base + int'($urandom_range(0, 7)) - 2;
                    v    = base;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: v = MIN_INT;
                        1: v = MAX_INT;
                        2: v = 0;
                        3: v = -1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            add_element(v, k == n - 1);
        end
    endtask

    // Long mostly increasing run that fills the table, then appends past full
    task automatic add_long_seq();
        int base;
        base = MIN_INT + 1000;
        for (int k = 0; k < 1060; k++) begin
            if ($urandom_range(0, 99) < 3) begin
                add_element(base - int'($urandom_range(1, 5000)), 0);
            end else begin
                base = base + int'($urandom_range(1, 1000));
                add_element(base, 0);
            end
        end
        for (int k = 0; k < 6; k++) begin
            base = base + int'($urandom_range(1, 1000));
            add_element(base, 0);
        end
        add_element(MIN_INT, 0);
        add_element(MAX_INT, 0);
        add_element(base - 10, 0);
        add_element(base, 1);
    endtask

    // Present one element and hold it until accepted
    task automatic send_element(t_element e, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = e.value;
        in_ch.last  = e.last;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_element(e.value, e.last);
    endtask

    // Result side: random stalls, checked on acceptance
    initial begin
        bit          burst;
        int          stall;
        t_lis_result got;
        burst = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 14);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.length   = out_ch.length;
            got.overflow = out_ch.overflow;
            got.done_res = out_ch.done_res;
            tracker.check_result(got);
        end
    end

    // Main sequence: reset, stimulus, drain, verdict
    initial begin
        bit burst;
        int gap;
        tracker      = new();
        burst        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;

        add_directed();
        while (elements_q.size() < 500) add_short_seq();
        add_long_seq();
        while (elements_q.size() < 2000) add_short_seq();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (elements_q[k]) begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 14);
            send_element(elements_q[k], gap);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
